@@ rtl/cfu_pkg.sv @@
package cfu_pkg;

  // Fixed configuration of the arithmetic
  localparam int CORDIC_STAGES  = 16;
  localparam int AXIS_FRAC_BITS = 14;
  localparam int CORDIC_N       = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  localparam int CIDX_W         = $clog2(CORDIC_N);

  // Datapath widths
  localparam int CW     = 34;   // CORDIC x/y/z
  localparam int TRIG_W = 32;   // Q30 sine/cosine, range [-2^30, 2^30]
  localparam int MUL_W  = 34;   // shared multiplier operands
  localparam int ACC_W  = 64;   // accumulator
  localparam int SQ_W   = 62;   // sum of squares
  localparam int NUM_W  = 61;   // divider numerator
  localparam int DEN_W  = 32;   // divider denominator
  localparam int QUO_W  = 31;   // divider quotient

  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032875;
  localparam logic signed [CW-1:0] TRIG_ONE  = 34'sd1073741824;

  // Unit axis component after reset
  localparam logic signed [15:0] AX_ONE =
    (AXIS_FRAC_BITS >= 15) ? 16'sd32767 : 16'(1 << AXIS_FRAC_BITS);

  // Command codes
  typedef enum logic [2:0] {
    OP_HOME   = 3'd0,
    OP_MOVE   = 3'd1,
    OP_ROT_R  = 3'd2,
    OP_ROT_U  = 3'd3,
    OP_ROT_B  = 3'd4,
    OP_AXIS   = 3'd5,
    OP_SETPOS = 3'd6,
    OP_UNUSED = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [15:0] angle;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [15:0] back_x;
    logic signed [15:0] back_y;
    logic signed [15:0] back_z;
    logic signed [31:0] place_x;
    logic signed [31:0] place_y;
    logic signed [31:0] place_z;
  } frame_t;

  // Multiplier-accumulator control
  typedef struct packed {
    logic issue;
    logic first;
  } mac_ctl_t;

  // Arctangent table in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10680862;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sd32767;
    else if (v < -64'sd32768) r = -16'sd32768;
    else r = 16'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

@@ rtl/camera_frame_update_core.sv @@
// Channel  Ports                              Direction  Payload
// command  in_valid / in_ready / in_data      in         cmd_t
// frame    out_valid / out_ready / out_data   out        frame_t
//
// One command at a time; in_ready is high only when no command is in work.
// Home, set position, unused opcode: the frame is offered in the next cycle.
// Axis-angle time is set mostly by the one-bit-per-cycle divider
// (three quotients) and the shared multiplier (about 50 products).
// Reset (rst_n low, synchronous) returns the frame home; out_ready stalls hold it.
module camera_frame_update_core import cfu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  cmd_t   in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output frame_t out_data
);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_CORDIC = 15'b000000000000010,
    ST_MOVE   = 15'b000000000000100,
    ST_ROT    = 15'b000000000001000,
    ST_NORM   = 15'b000000000010000,
    ST_SQSUM  = 15'b000000000100000,
    ST_SQRT   = 15'b000000001000000,
    ST_DIV    = 15'b000000010000000,
    ST_SA     = 15'b000000100000000,
    ST_AA     = 15'b000001000000000,
    ST_OM     = 15'b000010000000000,
    ST_SKEW   = 15'b000100000000000,
    ST_MAT    = 15'b001000000000000,
    ST_COMMIT = 15'b010000000000000,
    ST_OUT    = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt, dot_next;
  logic [3:0] grp_r, grp_nxt, n_grps;
  logic [2:0] term_r, term_nxt, k_terms;

  logic [2:0]         op_r;
  logic signed [31:0] vec_r [3];
  logic signed [15:0] ax_r [9];
  logic signed [15:0] nf_r [9];
  logic signed [31:0] place_r [3];
  logic signed [31:0] c_r, s_r;
  logic [31:0]        len_r;
  logic signed [31:0] a_r [3];
  logic signed [31:0] a2_r [3];
  logic signed [31:0] bq_r [3];
  logic signed [33:0] m3_r [9];

  logic accept, in_dot, issue, wb, last_grp;

  // Unit handshakes
  logic                     cordic_start, cordic_done;
  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic                     sqrt_start, sqrt_done;
  logic [31:0]              sqrt_root;
  logic                     div_start, div_done;
  logic [NUM_W-1:0]         div_num;
  logic [QUO_W-1:0]         div_quo;
  mac_ctl_t                 mac_ctl;
  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [ACC_W-1:0]  acc;

  // Index helpers
  logic [1:0] t, g3, gm, rot_j, a_sel;
  logic [3:0] gm_w, t3, pbase, qbase, ax_idx, m3_idx, rot_dst;
  logic signed [15:0] ax_rd;
  logic signed [33:0] m3_rd;
  logic signed [31:0] vec_rd, a_rd, a2_rd, vdiv;
  logic [31:0]        vmag, m0, m1, m2, mmax;
  logic               nm_zero, nm_big, nm_small;
  logic signed [63:0] rnd30, dmove, psum;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  // Group and term geometry of the multiply-accumulate passes
  always_comb begin
    in_dot   = 1'b1;
    k_terms  = 3'd1;
    n_grps   = 4'd1;
    dot_next = ST_IDLE;
    unique case (state_r)
      ST_MOVE:  begin k_terms = 3'd3; n_grps = 4'd3; dot_next = ST_OUT;    end
      ST_ROT:   begin k_terms = 3'd2; n_grps = 4'd6; dot_next = ST_COMMIT; end
      ST_SQSUM: begin k_terms = 3'd3; n_grps = 4'd1; dot_next = ST_SQRT;   end
      ST_SA:    begin k_terms = 3'd1; n_grps = 4'd3; dot_next = ST_AA;     end
      ST_AA:    begin k_terms = 3'd1; n_grps = 4'd9; dot_next = ST_OM;     end
      ST_OM:    begin k_terms = 3'd1; n_grps = 4'd9; dot_next = ST_SKEW;   end
      ST_MAT:   begin k_terms = 3'd3; n_grps = 4'd9; dot_next = ST_COMMIT; end
      default:  in_dot = 1'b0;
    endcase
  end

  assign issue    = in_dot && (term_r < k_terms);
  assign wb       = in_dot && (term_r == k_terms + 3'd1);
  assign last_grp = (grp_r == n_grps - 4'd1);

  // Row/column split of the group counter
  always_comb begin
    t = term_r[1:0];
    if (grp_r >= 4'd6) g3 = 2'd2;
    else if (grp_r >= 4'd3) g3 = 2'd1;
    else g3 = 2'd0;
    gm_w  = grp_r - 4'({g3, 1'b0}) - 4'(g3);
    gm    = gm_w[1:0];
    t3    = 4'({t, 1'b0}) + 4'(t);
    rot_j = (grp_r < 4'd3) ? grp_r[1:0] : gm;
  end

  // Axis pair for the plane rotations
  always_comb begin
    pbase = 4'd0;
    qbase = 4'd3;
    unique case (op_r)
      OP_ROT_R: begin pbase = 4'd3; qbase = 4'd6; end
      OP_ROT_U: begin pbase = 4'd6; qbase = 4'd0; end
      default:  begin pbase = 4'd0; qbase = 4'd3; end
    endcase
    rot_dst = ((grp_r < 4'd3) ? pbase : qbase) + 4'(rot_j);
  end

  // Register-file read ports
  always_comb begin
    unique case (state_r)
      ST_MOVE: ax_idx = t3 + grp_r;
      ST_ROT:  ax_idx = ((t == 2'd0) ? pbase : qbase) + 4'(rot_j);
      ST_MAT:  ax_idx = t3 + 4'(gm);
      default: ax_idx = 4'd0;
    endcase
    m3_idx = (state_r == ST_OM) ? grp_r : t3 + 4'(g3);
    a_sel  = (state_r == ST_SA) ? grp_r[1:0] : g3;
    ax_rd  = (ax_idx <= 4'd8) ? ax_r[ax_idx] : '0;
    m3_rd  = (m3_idx <= 4'd8) ? m3_r[m3_idx] : '0;
    vec_rd = (t <= 2'd2) ? vec_r[t] : '0;
    a_rd   = (a_sel <= 2'd2) ? a_r[a_sel] : '0;
    a2_rd  = (gm <= 2'd2) ? a2_r[gm] : '0;
    vmag   = mag32(vec_rd);
  end

  // Operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      ST_MOVE: begin op_a = MUL_W'(vec_rd); op_b = MUL_W'(ax_rd); end
      ST_ROT: begin
        if (grp_r < 4'd3) op_a = (t == 2'd0) ? MUL_W'(c_r) : MUL_W'(s_r);
        else op_a = (t == 2'd0) ? -MUL_W'(s_r) : MUL_W'(c_r);
        op_b = MUL_W'(ax_rd);
      end
      ST_SQSUM: begin op_a = $signed({2'b00, vmag}); op_b = $signed({2'b00, vmag}); end
      ST_SA:    begin op_a = MUL_W'(s_r); op_b = MUL_W'(a_rd); end
      ST_AA:    begin op_a = MUL_W'(a_rd); op_b = MUL_W'(a2_rd); end
      ST_OM:    begin op_a = TRIG_ONE - MUL_W'(c_r); op_b = m3_rd; end
      ST_MAT:   begin op_a = m3_rd; op_b = MUL_W'(ax_rd); end
      default:  begin op_a = '0; op_b = '0; end
    endcase
  end

  assign mac_ctl.issue = issue;
  assign mac_ctl.first = (term_r == 3'd0);

  // Rounding of the accumulated sum
  assign rnd30 = (acc + 64'sd536870912) >>> 30;
  assign dmove = (acc + (64'sd1 <<< (AXIS_FRAC_BITS - 1))) >>> AXIS_FRAC_BITS;
  assign psum  = 64'(place_r[grp_r[1:0]]) + dmove;

  // Axis scaling: largest magnitude brought into [2^29, 2^30)
  always_comb begin
    m0       = mag32(vec_r[0]);
    m1       = mag32(vec_r[1]);
    m2       = mag32(vec_r[2]);
    mmax     = (m1 > m0) ? m1 : m0;
    mmax     = (m2 > mmax) ? m2 : mmax;
    nm_zero  = (mmax == '0);
    nm_big   = (mmax[31:30] != 2'b00);
    nm_small = !nm_big && !mmax[29];
  end

  // Unit control
  assign cordic_start = accept && (in_data.opcode >= OP_ROT_R) && (in_data.opcode <= OP_AXIS);
  assign sqrt_start   = wb && (state_r == ST_SQSUM);
  assign div_start    = (state_r == ST_DIV) && (term_r == 3'd0);
  assign vdiv         = vec_r[grp_r[1:0]];
  assign div_num      = (NUM_W'(mag32(vdiv)) << 30) + NUM_W'(len_r >> 1);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    term_nxt  = term_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.opcode)
            OP_MOVE:                     state_nxt = ST_MOVE;
            OP_ROT_R, OP_ROT_U, OP_ROT_B: state_nxt = ST_CORDIC;
            OP_AXIS:                     state_nxt = ST_CORDIC;
            default:                     state_nxt = ST_OUT;
          endcase
        end
      end
      ST_CORDIC: begin
        if (cordic_done) state_nxt = (op_r == OP_AXIS) ? ST_NORM : ST_ROT;
      end
      ST_NORM: begin
        if (nm_zero) state_nxt = ST_OUT;
        else if (!nm_big && !nm_small) state_nxt = ST_SQSUM;
      end
      ST_SQRT: begin
        if (sqrt_done) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (term_r == 3'd0) begin
          term_nxt = 3'd1;
        end else if (div_done) begin
          term_nxt = 3'd0;
          if (grp_r == 4'd2) begin
            grp_nxt   = 4'd0;
            state_nxt = ST_SA;
          end else begin
            grp_nxt = grp_r + 4'd1;
          end
        end
      end
      ST_MOVE, ST_ROT, ST_SQSUM, ST_SA, ST_AA, ST_OM, ST_MAT: begin
        if (wb) begin
          term_nxt = 3'd0;
          if (last_grp) begin
            grp_nxt   = 4'd0;
            state_nxt = dot_next;
          end else begin
            grp_nxt = grp_r + 4'd1;
          end
        end else begin
          term_nxt = term_r + 3'd1;
        end
      end
      ST_SKEW:   state_nxt = ST_MAT;
      ST_COMMIT: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      grp_r   <= '0;
      term_r  <= '0;
      for (int i = 0; i < 9; i++) ax_r[i] <= (i % 4 == 0) ? AX_ONE : '0;
      for (int i = 0; i < 3; i++) place_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      grp_r   <= grp_nxt;
      term_r  <= term_nxt;
      if (accept && in_data.opcode == OP_HOME) begin
        for (int i = 0; i < 9; i++) ax_r[i] <= (i % 4 == 0) ? AX_ONE : '0;
        for (int i = 0; i < 3; i++) place_r[i] <= '0;
      end
      if (accept && in_data.opcode == OP_SETPOS) begin
        place_r[0] <= in_data.vec_x;
        place_r[1] <= in_data.vec_y;
        place_r[2] <= in_data.vec_z;
      end
      if (wb && state_r == ST_MOVE) place_r[grp_r[1:0]] <= sat32(psum);
      if (state_r == ST_COMMIT) begin
        for (int i = 0; i < 9; i++) ax_r[i] <= nf_r[i];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_data.opcode;
      vec_r[0] <= in_data.vec_x;
      vec_r[1] <= in_data.vec_y;
      vec_r[2] <= in_data.vec_z;
      for (int i = 0; i < 9; i++) nf_r[i] <= ax_r[i];
    end
    if (cordic_done) begin
      c_r <= cos_q;
      s_r <= sin_q;
    end
    if (state_r == ST_NORM && !nm_zero) begin
      for (int i = 0; i < 3; i++) begin
        if (nm_big) vec_r[i] <= vec_r[i] >>> 1;
        else if (nm_small) vec_r[i] <= vec_r[i] <<< 1;
      end
    end
    if (wb) begin
      unique case (state_r)
        ST_ROT: nf_r[rot_dst] <= sat16(rnd30);
        ST_SA:  bq_r[grp_r[1:0]] <= 32'(rnd30);
        ST_AA:  m3_r[grp_r] <= 34'(rnd30);
        ST_OM:  m3_r[grp_r] <= ((g3 == gm) ? 34'(c_r) : 34'sd0) + 34'(rnd30);
        ST_MAT: nf_r[grp_r] <= sat16(rnd30);
        default: ;
      endcase
    end
    if (sqrt_done) len_r <= sqrt_root;
    if (div_done) begin
      a_r[grp_r[1:0]]  <= vdiv[31] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      a2_r[grp_r[1:0]] <= vdiv[31] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    end
    // Cross-product terms of the rotation matrix
    if (state_r == ST_SKEW) begin
      m3_r[1] <= m3_r[1] - 34'(bq_r[2]);
      m3_r[3] <= m3_r[3] + 34'(bq_r[2]);
      m3_r[2] <= m3_r[2] + 34'(bq_r[1]);
      m3_r[6] <= m3_r[6] - 34'(bq_r[1]);
      m3_r[5] <= m3_r[5] - 34'(bq_r[0]);
      m3_r[7] <= m3_r[7] + 34'(bq_r[0]);
    end
  end

  cfu_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (in_data.angle),
    .done  (cordic_done),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  cfu_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value (acc[SQ_W-1:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  cfu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (len_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  cfu_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  // Result fields
  assign out_data.right_x = ax_r[0];
  assign out_data.right_y = ax_r[1];
  assign out_data.right_z = ax_r[2];
  assign out_data.up_x    = ax_r[3];
  assign out_data.up_y    = ax_r[4];
  assign out_data.up_z    = ax_r[5];
  assign out_data.back_x  = ax_r[6];
  assign out_data.back_y  = ax_r[7];
  assign out_data.back_z  = ax_r[8];
  assign out_data.place_x = place_r[0];
  assign out_data.place_y = place_r[1];
  assign out_data.place_z = place_r[2];

  // Command and result sides never open together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("in_ready and out_valid both high");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready) else $error("ready right after accepting an item");

  a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_done |-> state_r == ST_CORDIC) else $error("CORDIC finished out of sequence");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV) else $error("divider finished out of sequence");

  a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == ST_SQRT) else $error("square root finished out of sequence");

endmodule

@@ rtl/cfu_cordic.sv @@
module cfu_cordic import cfu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [15:0]       angle,
  output logic                     done,
  output logic signed [TRIG_W-1:0] cos_q,
  output logic signed [TRIG_W-1:0] sin_q
);

  logic              busy_r, done_r, neg_r;
  logic [CIDX_W-1:0] idx_r;
  logic signed [CW-1:0] x_r, y_r, z_r;

  logic signed [16:0]   t_raw, t_fold;
  logic                 fold_neg;
  logic signed [CW-1:0] z0, dx, dy, at, xf, yf;

  // Fold the angle into [-quarter, +quarter] turn
  always_comb begin
    t_raw    = 17'(angle);
    t_fold   = t_raw;
    fold_neg = 1'b0;
    if (t_raw > 17'sd16384) begin
      t_fold   = t_raw - 17'sd32768;
      fold_neg = 1'b1;
    end else if (t_raw < -17'sd16384) begin
      t_fold   = t_raw + 17'sd32768;
      fold_neg = 1'b1;
    end
    z0 = CW'(t_fold) <<< 16;
  end

  // One micro-rotation per cycle
  assign dx = y_r >>> idx_r;
  assign dy = x_r >>> idx_r;
  assign at = $signed({4'b0000, atan_turn(5'(idx_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == CIDX_W'(CORDIC_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= CORDIC_X0;
      y_r   <= '0;
      z_r   <= z0;
      neg_r <= fold_neg;
    end else if (busy_r) begin
      if (!z_r[CW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  // Undo the fold and clamp to unit range
  always_comb begin
    xf = neg_r ? -x_r : x_r;
    yf = neg_r ? -y_r : y_r;
    if (xf > TRIG_ONE) xf = TRIG_ONE;
    else if (xf < -TRIG_ONE) xf = -TRIG_ONE;
    if (yf > TRIG_ONE) yf = TRIG_ONE;
    else if (yf < -TRIG_ONE) yf = -TRIG_ONE;
  end

  assign cos_q = TRIG_W'(xf);
  assign sin_q = TRIG_W'(yf);
  assign done  = done_r;

endmodule

@@ rtl/cfu_isqrt.sv @@
module cfu_isqrt import cfu_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SQ_W-1:0] value,
  output logic            done,
  output logic [31:0]     root
);

  logic        busy_r, done_r;
  logic [63:0] v_r, r_r, bit_r, sum;
  logic        ge;

  // Digit-by-digit integer square root: the test bit moves down two places each step
  assign sum = r_r + bit_r;
  assign ge  = (v_r >= sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= 64'(value);
      r_r   <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (ge) begin
        v_r <= v_r - sum;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

@@ rtl/cfu_div.sv @@
module cfu_div import cfu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  logic             busy_r, done_r;
  logic [4:0]       cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] low_r, q_r;
  logic [DEN_W:0]   sh;
  logic             qbit;

  // Restoring division, one quotient bit per cycle
  assign sh   = {rem_r, low_r[QUO_W-1]};
  assign qbit = (sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient is known to fit in QUO_W bits, so the top bits seed the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(num[NUM_W-1:QUO_W]);
      low_r <= num[QUO_W-1:0];
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? DEN_W'(sh - {1'b0, den}) : sh[DEN_W-1:0];
      low_r <= low_r << 1;
      q_r   <= {q_r[QUO_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ rtl/cfu_mac.sv @@
module cfu_mac import cfu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctl_t                ctl,
  input  logic signed [MUL_W-1:0] op_a,
  input  logic signed [MUL_W-1:0] op_b,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]   p_r, acc_r;
  logic                      pv_r, pf_r;

  // Product registered, accumulated in the next cycle
  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      pf_r <= 1'b0;
    end else begin
      pv_r <= ctl.issue;
      pf_r <= ctl.first;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= prod[ACC_W-1:0];
    if (pv_r) acc_r <= (pf_r ? '0 : acc_r) + p_r;
  end

  assign acc = acc_r;

endmodule
